[src/rdq_pkg.sv]
// rdq_pkg: shared types and field widths for the ring deque block.
// Opcode and status codes, plus the packing widths of the stream words.
// No dependencies.
`default_nettype none

package rdq_pkg;

	// field widths of one input word and one result word
	localparam int OPCODE_W    = 3;
	localparam int POS_W       = 4;
	localparam int VALUE_W     = 32;
	localparam int RESULT_W    = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// low bit of each input field inside s_axis_tdata
	localparam int POS_LSB   = OPCODE_W;
	localparam int VALUE_LSB = OPCODE_W + POS_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD_HIGH    = 3'd0,
		OP_ADD_LOW     = 3'd1,
		OP_REMOVE_HIGH = 3'd2,
		OP_REMOVE_LOW  = 3'd3,
		OP_GET         = 3'd4,
		OP_PUT         = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

[src/rdq_ram.sv]
// rdq_ram: generic single-clock RAM, one write port and one read port.
// Registered read, read-first: a read and a write to the same address in
// one cycle return the old word. No dependencies.
`default_nettype none

module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// storage and read register; no reset on payload
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/ring_deque_indexed_unit.sv]
// ring_deque_indexed_unit: double-ended queue of CAPACITY words in a ring.
// Depends on rdq_pkg and rdq_ram.
//
// Usage:
//   Commands arrive on the s_axis channel, one word each: opcode, position
//   and value. Every command gives exactly one result word on m_axis:
//   result value, status and the element count after the command.
//   Ops: add high, add low, remove high, remove low, get at a logical
//   index, put at a logical index (put returns the replaced word).
//   An add when full, a remove when empty or an index not below the count
//   reports an error status, returns zero and leaves the deque as it was.
//   Unused opcodes return zero with status ok and change nothing.
//   Pipeline: an accepted command goes through the read stage (RAM read
//   register and stage payload), then the output register, to m_axis.
//   Throughput: one command per cycle unless m_axis stalls; head and count
//   update on accept, and the single RAM slot is read and written at once.
//   Stalls: when m_axis_tready is low the result is held in the output
//   register, one more result waits in the read stage, then s_axis_tready
//   drops until the output drains.
//   Reset (arst_n low) empties the deque and the pipeline; RAM contents are
//   not cleared, slots are only read after they were written.
`default_nettype none

module ring_deque_indexed_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_axis_tdata: opcode[2:0], position[6:3], value[38:7], zero pad [39]
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [rdq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// m_axis_tdata: result_value[31:0], status[33:32], count[38:34], pad [39]
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [rdq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	import rdq_pkg::*;

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int XW  = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int PAD = OUT_TDATA_W - RESULT_W - STATUS_W - COUNT_OUT_W;

	// deque state
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	// read stage
	logic                   valid_s1;
	status_t                status_s1;
	logic [COUNT_OUT_W-1:0] count_s1;
	logic [RESULT_W-1:0]    val_s1;
	logic                   sel_ram_s1;

	// output register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// input fields
	logic [OPCODE_W-1:0] in_opcode;
	logic [POS_W-1:0]    in_pos;
	logic [VALUE_W-1:0]  in_value;
	op_t                 op;

	logic [63:0]           val_ext;
	logic [DATA_WIDTH-1:0] wr_word;
	logic [RESULT_W-1:0]   val_masked;
	logic [63:0]           rd_ext;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [RESULT_W-1:0]   result_word;

	logic full, empty, in_range;
	logic accept, adv;

	status_t       st_d;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	logic [AW-1:0] slot;
	logic          we_d, re_d, use_val_d;
	logic [AW-1:0] head_dec, head_inc;

	// logical index -> ring slot, idx + head stays below twice the capacity
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
			input logic [XW-1:0] idx);
		logic [XW-1:0] sum;
		sum = XW'(head) + idx;
		if (sum >= XW'(CAPACITY)) begin
			sum = sum - XW'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	assign in_opcode = s_axis_tdata[OPCODE_W-1:0];
	assign in_pos    = s_axis_tdata[POS_LSB +: POS_W];
	assign in_value  = s_axis_tdata[VALUE_LSB +: VALUE_W];
	assign op        = op_t'(in_opcode);

	// element words are kept at DATA_WIDTH bits
	assign val_ext    = 64'(in_value);
	assign wr_word    = val_ext[DATA_WIDTH-1:0];
	assign val_masked = RESULT_W'(wr_word);

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_range = (XW'(in_pos) < XW'(count_q));

	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

	// handshake: the read stage frees when it moves to the output register
	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// command decode: next head, next count, slot and RAM strobes
	always_comb begin
		st_d      = ST_OK;
		head_d    = head_q;
		count_d   = count_q;
		slot      = head_q;
		we_d      = 1'b0;
		re_d      = 1'b0;
		use_val_d = 1'b0;
		unique case (op)
			OP_ADD_HIGH: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					slot      = slot_of(head_q, XW'(count_q));
					we_d      = 1'b1;
					use_val_d = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			OP_ADD_LOW: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					slot      = head_dec;
					head_d    = head_dec;
					we_d      = 1'b1;
					use_val_d = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			OP_REMOVE_HIGH: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					slot    = slot_of(head_q, XW'(count_q) - XW'(1));
					re_d    = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			OP_REMOVE_LOW: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					slot    = head_q;
					head_d  = head_inc;
					re_d    = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			OP_GET: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					slot = slot_of(head_q, XW'(in_pos));
					re_d = 1'b1;
				end
			end
			OP_PUT: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					slot = slot_of(head_q, XW'(in_pos));
					re_d = 1'b1;
					we_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// element store; a put reads the old word while writing the new one
	rdq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (accept && we_d),
		.waddr(slot),
		.wdata(wr_word),
		.re   (accept && re_d),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// head and count update at the accept edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// read stage: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= st_d;
			count_s1   <= COUNT_OUT_W'(count_d);
			val_s1     <= use_val_d ? val_masked : '0;
			sel_ram_s1 <= re_d;
		end
	end

	assign rd_ext      = 64'(ram_rdata);
	assign result_word = sel_ram_s1 ? rd_ext[RESULT_W-1:0] : val_s1;

	// output register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register: result word
	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {PAD'(0), count_s1, status_s1, result_word};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
